FILE: rtl/core/iqc_pkg.sv
// ----------------------------------------------------------------------------
// iqc_pkg
// Shared constants, operation and status codes, and inter-module structs for
// the interrupt queue controller.
// ----------------------------------------------------------------------------
package iqc_pkg;

    // Queue and nesting limits
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = 5;
    localparam int MAX_NEST    = 8;
    localparam int NEST_W      = 4;

    // Field widths
    localparam int OP_W   = 4;
    localparam int VEC_W  = 8;
    localparam int ADDR_W = 32;
    localparam int STAT_W = 3;

    // Handler table
    localparam int TBL_DEPTH = 256;

    // Item packing
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_NMI_VECTOR = '0;
    localparam logic [VEC_W-1:0]  NMI_RESET      = 8'd2;

    localparam logic [VEC_W-1:0] EMPTY_VECTOR = 8'hFF;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RAISE   = 4'd0;
    localparam logic [OP_W-1:0] OP_TAKE    = 4'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 4'd2;
    localparam logic [OP_W-1:0] OP_SET_HDL = 4'd3;
    localparam logic [OP_W-1:0] OP_RD_HDL  = 4'd4;
    localparam logic [OP_W-1:0] OP_ENTER   = 4'd5;
    localparam logic [OP_W-1:0] OP_EXIT    = 4'd6;
    localparam logic [OP_W-1:0] OP_ENABLE  = 4'd7;
    localparam logic [OP_W-1:0] OP_DISABLE = 4'd8;
    localparam logic [OP_W-1:0] OP_SRESET  = 4'd9;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_MASKED = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVER   = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNDER  = 3'd4;

    // Memory commands issued by the controller
    typedef struct packed {
        logic             fifo_we;
        logic             fifo_re;
        logic [PTR_W-1:0] fifo_waddr;
        logic [PTR_W-1:0] fifo_raddr;
        logic             tbl_we;
        logic             tbl_re;
        logic             tbl_clear;
    } iqc_mem_cmd_t;

    // Per-item result fields known at issue time
    typedef struct packed {
        logic              take_hit;
        logic              take_empty;
        logic              rd_handler;
        logic              pending;
        logic [NEST_W-1:0] nest;
        logic [FILL_W-1:0] fill;
        logic [STAT_W-1:0] status;
    } iqc_res_t;

endpackage

FILE: rtl/core/interrupt_queue_controller.sv
// ----------------------------------------------------------------------------
// interrupt_queue_controller
// Interrupt vector FIFO with non-maskable vector, handler table and
// nesting counter; one operation per item, one result item per operation.
// ----------------------------------------------------------------------------
//  Port group   Direction  Carries
//  s_*          in         operation items (op, vector, isr_addr)
//  m_*          out        result items (vector, flags, handler, levels)
//  APB          in/out     nmi_vector register at byte address 0
//
//  One item per cycle sustained while the m_ side does not stall. The
//  accepting s_ edge starts the synchronous memory read and loads the read
//  stage; the read stage then loads the m_ output register.
//  aresetn is synchronous; it clears pointers, counts and all handler
//  valid bits at once and sets the enable flag, so no clearing pass is needed.
//  A stalled m_ side holds the output register; one more item may enter
//  and park in the read stage, after which s_tready drops.
// ----------------------------------------------------------------------------
module interrupt_queue_controller (
    input  logic                           aclk,
    input  logic                           aresetn,

    // [3:0] op, [11:4] vector, [43:12] isr_addr, [47:44] zero
    input  logic [iqc_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,

    // [7:0] vector_out, [8] queue_empty, [9] pending, [41:10] handler_out,
    // [45:42] nesting_depth, [50:46] queue_fill, [53:51] status, [55:54] zero
    output logic [iqc_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iqc_pkg::APB_AW-1:0]     paddr,
    input  logic [iqc_pkg::APB_DW-1:0]     pwdata,
    output logic [iqc_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import iqc_pkg::*;

    // ---- configuration register ----
    logic [VEC_W-1:0] nmi_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nmi_reg <= NMI_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_AW-1:2] == REG_NMI_VECTOR) begin
            nmi_reg <= pwdata[VEC_W-1:0];
        end
    end

    assign prdata = (paddr[APB_AW-1:2] == REG_NMI_VECTOR)
                    ? APB_DW'(nmi_reg) : '0;

    // ---- input unpack ----
    logic [OP_W-1:0]   in_op;
    logic [VEC_W-1:0]  in_vec;
    logic [ADDR_W-1:0] in_addr;

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_vec  = s_tdata[OP_W+VEC_W-1:OP_W];
    assign in_addr = s_tdata[OP_W+VEC_W+ADDR_W-1:OP_W+VEC_W];

    // ---- handshake and stage control ----
    logic     s1_valid_reg;
    iqc_res_t s1_res_reg;
    logic     out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic     s1_adv;
    logic     accept;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // ---- decode and scalar state ----
    iqc_mem_cmd_t cmd;
    iqc_res_t     res;

    iqc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (in_op),
        .vector     (in_vec),
        .nmi_vector (nmi_reg),
        .cmd        (cmd),
        .res        (res)
    );

    // ---- memories ----
    logic [VEC_W-1:0]  fifo_rdata;
    logic [ADDR_W-1:0] tbl_rdata;

    iqc_fifo_mem u_fifo (
        .aclk  (aclk),
        .we    (cmd.fifo_we),
        .waddr (cmd.fifo_waddr),
        .wdata (in_vec),
        .re    (cmd.fifo_re),
        .raddr (cmd.fifo_raddr),
        .rdata (fifo_rdata)
    );

    iqc_handler_mem u_hdl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cmd.tbl_clear),
        .we      (cmd.tbl_we),
        .re      (cmd.tbl_re),
        .addr    (in_vec),
        .wdata   (in_addr),
        .rdata   (tbl_rdata)
    );

    // ---- read stage: holds result fields while memory data arrives ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_res_reg <= res;
        end
    end

    // ---- result assembly ----
    logic [VEC_W-1:0]  vec_out;
    logic [ADDR_W-1:0] hdl_out;

    always_comb begin
        if (s1_res_reg.take_hit) begin
            vec_out = fifo_rdata;
        end else if (s1_res_reg.take_empty) begin
            vec_out = EMPTY_VECTOR;
        end else begin
            vec_out = '0;
        end
        hdl_out = s1_res_reg.rd_handler ? tbl_rdata : '0;

        out_data_next = {2'b00, s1_res_reg.status, s1_res_reg.fill, s1_res_reg.nest,
                         hdl_out, s1_res_reg.pending, s1_res_reg.take_empty, vec_out};
    end

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/iqc_fifo_mem.sv
// ----------------------------------------------------------------------------
// iqc_fifo_mem
// Pending-vector store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module iqc_fifo_mem (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [iqc_pkg::PTR_W-1:0]  waddr,
    input  logic [iqc_pkg::VEC_W-1:0]  wdata,
    input  logic                       re,
    input  logic [iqc_pkg::PTR_W-1:0]  raddr,
    output logic [iqc_pkg::VEC_W-1:0]  rdata
);
    import iqc_pkg::*;

    logic [VEC_W-1:0] mem [QUEUE_DEPTH];
    logic [VEC_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/iqc_handler_mem.sv
// ----------------------------------------------------------------------------
// iqc_handler_mem
// Handler address table with per-entry valid bits; an entry not written
// since the last reset or soft reset reads as zero.
// ----------------------------------------------------------------------------
module iqc_handler_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        we,
    input  logic                        re,
    input  logic [iqc_pkg::VEC_W-1:0]   addr,
    input  logic [iqc_pkg::ADDR_W-1:0]  wdata,
    output logic [iqc_pkg::ADDR_W-1:0]  rdata
);
    import iqc_pkg::*;

    logic [ADDR_W-1:0]    mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] valid_reg;
    logic [ADDR_W-1:0]    rdata_reg;
    logic                 hit_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
            hit_reg   <= valid_reg[addr];
        end
    end

    assign rdata = hit_reg ? rdata_reg : '0;

endmodule

FILE: rtl/core/iqc_ctrl.sv
// ----------------------------------------------------------------------------
// iqc_ctrl
// Operation decode and scalar state: queue pointers, fill count, enable,
// nesting level. Issues memory commands and the early result fields.
// ----------------------------------------------------------------------------
module iqc_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [iqc_pkg::OP_W-1:0]   op,
    input  logic [iqc_pkg::VEC_W-1:0]  vector,
    input  logic [iqc_pkg::VEC_W-1:0]  nmi_vector,
    output iqc_pkg::iqc_mem_cmd_t      cmd,
    output iqc_pkg::iqc_res_t          res
);
    import iqc_pkg::*;

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);
    localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NEST);

    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              en_reg, en_next;
    logic [NEST_W-1:0] nest_reg, nest_next;

    always_comb begin
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        en_next   = en_reg;
        nest_next = nest_reg;
        cmd       = '0;
        cmd.fifo_waddr = wp_reg;
        cmd.fifo_raddr = rp_reg;
        res       = '0;
        res.status = ST_OK;

        unique case (op)
            OP_RAISE: begin
                if (fill_reg == FILL_MAX) begin
                    res.status = ST_FULL;
                end else if (vector == nmi_vector || en_reg) begin
                    cmd.fifo_we = 1'b1;
                    wp_next     = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    fill_next   = fill_reg + 1'b1;
                end else begin
                    res.status = ST_MASKED;
                end
            end
            OP_TAKE: begin
                if (fill_reg == '0) begin
                    res.take_empty = 1'b1;
                end else begin
                    res.take_hit = 1'b1;
                    cmd.fifo_re  = 1'b1;
                    rp_next      = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                    fill_next    = fill_reg - 1'b1;
                end
            end
            OP_CLEAR: begin
                rp_next   = '0;
                wp_next   = '0;
                fill_next = '0;
            end
            OP_SET_HDL: cmd.tbl_we = 1'b1;
            OP_RD_HDL: begin
                cmd.tbl_re     = 1'b1;
                res.rd_handler = 1'b1;
            end
            OP_ENTER: begin
                if (nest_reg < NEST_MAX) begin
                    nest_next = nest_reg + 1'b1;
                end else begin
                    res.status = ST_OVER;
                end
            end
            OP_EXIT: begin
                if (nest_reg != '0) begin
                    nest_next = nest_reg - 1'b1;
                end else begin
                    res.status = ST_UNDER;
                end
            end
            OP_ENABLE:  en_next = 1'b1;
            OP_DISABLE: en_next = 1'b0;
            OP_SRESET: begin
                en_next       = 1'b1;
                nest_next     = '0;
                rp_next       = '0;
                wp_next       = '0;
                fill_next     = '0;
                cmd.tbl_clear = 1'b1;
            end
            default: ;
        endcase

        // gate every side effect with the handshake
        if (!accept) begin
            cmd.fifo_we   = 1'b0;
            cmd.fifo_re   = 1'b0;
            cmd.tbl_we    = 1'b0;
            cmd.tbl_re    = 1'b0;
            cmd.tbl_clear = 1'b0;
        end

        res.fill    = fill_next;
        res.nest    = nest_next;
        res.pending = (fill_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            fill_reg <= '0;
            en_reg   <= 1'b1;
            nest_reg <= '0;
        end else if (accept) begin
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            en_reg   <= en_next;
            nest_reg <= nest_next;
        end
    end

endmodule

FILE: verif/iqc_checker.sv
// ----------------------------------------------------------------------------
// iqc_checker
// Watches the operation, result and APB channels of the interrupt queue
// controller, predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------
module iqc_checker (
    input  logic                         aclk,
    input  logic                         aresetn,

    // [3:0] op, [11:4] vector, [43:12] isr_addr, [47:44] zero
    input  logic [iqc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,

    // [7:0] vector_out, [8] queue_empty, [9] pending, [41:10] handler_out,
    // [45:42] nesting_depth, [50:46] queue_fill, [53:51] status, [55:54] zero
    input  logic [iqc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [iqc_pkg::APB_AW-1:0]   paddr,
    input  logic [iqc_pkg::APB_DW-1:0]   pwdata,
    input  logic [iqc_pkg::APB_DW-1:0]   prdata,
    input  logic                         pready,

    output int                           fail_count,
    output int                           results_owed
);
    import iqc_pkg::*;

    // first member lands in the top bits
    typedef struct packed {
        logic [M_DATA_W-55:0] zero_fill;
        logic [STAT_W-1:0]    status;
        logic [FILL_W-1:0]    queue_fill;
        logic [NEST_W-1:0]    nesting_depth;
        logic [ADDR_W-1:0]    handler_out;
        logic                 pending;
        logic                 queue_empty;
        logic [VEC_W-1:0]     vector_out;
    } irq_result_t;

    logic [VEC_W-1:0]  nmi_vec;
    logic [VEC_W-1:0]  vector_fifo [QUEUE_DEPTH];
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    logic [FILL_W-1:0] fill;
    logic              irq_en;
    logic [NEST_W-1:0] nest;
    logic [ADDR_W-1:0] handler_tbl [TBL_DEPTH];

    irq_result_t owed_results [$];

    function automatic void restart_state();
        irq_en = 1'b1;
        nest   = '0;
        rd_ptr = '0;
        wr_ptr = '0;
        fill   = '0;
        for (int i = 0; i < TBL_DEPTH; i++) handler_tbl[i] = '0;
    endfunction

    function automatic irq_result_t apply_operation(logic [OP_W-1:0]   op,
                                                    logic [VEC_W-1:0]  vec,
                                                    logic [ADDR_W-1:0] addr);
        irq_result_t r;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_RAISE: begin
                // full check comes before the mask
                if (fill >= FILL_W'(QUEUE_DEPTH)) begin
                    r.status = ST_FULL;
                end else if (vec == nmi_vec || irq_en) begin
                    vector_fifo[wr_ptr] = vec;
                    wr_ptr = wr_ptr + 1'b1;
                    fill   = fill + 1'b1;
                end else begin
                    r.status = ST_MASKED;
                end
            end
            OP_TAKE: begin
                if (fill == '0) begin
                    r.vector_out  = EMPTY_VECTOR;
                    r.queue_empty = 1'b1;
                end else begin
                    r.vector_out = vector_fifo[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                    fill   = fill - 1'b1;
                end
            end
            OP_CLEAR: begin
                rd_ptr = '0;
                wr_ptr = '0;
                fill   = '0;
            end
            OP_SET_HDL: handler_tbl[vec] = addr;
            OP_RD_HDL:  r.handler_out = handler_tbl[vec];
            OP_ENTER: begin
                if (nest < NEST_W'(MAX_NEST)) nest = nest + 1'b1;
                else r.status = ST_OVER;
            end
            OP_EXIT: begin
                if (nest != '0) nest = nest - 1'b1;
                else r.status = ST_UNDER;
            end
            OP_ENABLE:  irq_en = 1'b1;
            OP_DISABLE: irq_en = 1'b0;
            OP_SRESET:  restart_state();
            default: ;
        endcase
        r.pending       = (fill != '0);
        r.nesting_depth = nest;
        r.queue_fill    = fill;
        return r;
    endfunction

    task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        irq_result_t seen;
        irq_result_t want;
        if (!aresetn) begin
            nmi_vec = NMI_RESET;
            restart_state();
            owed_results.delete();
        end else begin
            if (psel && penable && pready && paddr[APB_AW-1:2] == REG_NMI_VECTOR) begin
                if (pwrite)
                    nmi_vec = pwdata[VEC_W-1:0];
                else
                    check_field("nmi_vector", ADDR_W'(nmi_vec), prdata);
            end

            // push first so that a same-edge result can still find its entry
            if (s_tvalid && s_tready)
                owed_results.push_back(apply_operation(s_tdata[OP_W-1:0],
                                                       s_tdata[OP_W +: VEC_W],
                                                       s_tdata[OP_W+VEC_W +: ADDR_W]));

            if (m_tvalid && m_tready) begin
                seen = irq_result_t'(m_tdata);
                if (owed_results.size() == 0) begin
                    $error("result item with nothing expected: 0x%0h", m_tdata);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("vector_out", ADDR_W'(want.vector_out),
                                ADDR_W'(seen.vector_out));
                    check_field("queue_empty", ADDR_W'(want.queue_empty),
                                ADDR_W'(seen.queue_empty));
                    check_field("pending", ADDR_W'(want.pending), ADDR_W'(seen.pending));
                    check_field("handler_out", want.handler_out, seen.handler_out);
                    check_field("nesting_depth", ADDR_W'(want.nesting_depth),
                                ADDR_W'(seen.nesting_depth));
                    check_field("queue_fill", ADDR_W'(want.queue_fill),
                                ADDR_W'(seen.queue_fill));
                    check_field("status", ADDR_W'(want.status), ADDR_W'(seen.status));
                end
            end
        end
        results_owed = owed_results.size();
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives operation items and nmi_vector writes into the interrupt queue
// controller under random gaps and stalls; iqc_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import iqc_pkg::*;

    // op codes with no meaning: the block must leave all state alone
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_SRESET + 1'b1;
    localparam logic [OP_W-1:0] OP_LAST_CODE    = {OP_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = {ADDR_W{1'b1}};
    localparam int PHASE_ITEMS = 300;
    localparam int NUM_PHASES  = 6;

    logic                aclk;
    logic                aresetn;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  results_owed;
    int                  items_sent;
    logic [VEC_W-1:0]    nmi_now;       // mirror of the register, for biasing raises
    bit                  input_calm;    // no gaps on the operation side
    bit                  output_calm;   // no stalls on the result side

    interrupt_queue_controller u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    iqc_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // a quarter of vectors hit the NMI, a few the extremes
    function automatic logic [VEC_W-1:0] pick_vector();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return nmi_now;
        if (r < 30) return '0;
        if (r < 35) return '1;
        return VEC_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return ADDR_ALL_ONES;
        return $urandom();
    endfunction

    // one item on the operation channel; called at a rising edge, returns at
    // the edge that accepted it, tvalid still high for a possible next item
    task automatic send_op(logic [OP_W-1:0] op, logic [VEC_W-1:0] vec,
                           logic [ADDR_W-1:0] addr);
        int gap;
        gap = input_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-OP_W-VEC_W-ADDR_W){1'b0}}, addr, vec, op};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // drop tvalid, let every owed result drain and the pipeline go idle
    // before touching the register
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    // setup then access cycle; ends on the edge after the access so the next
    // transfer starts in a fresh time step
    task automatic apb_access(bit wr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_NMI_VECTOR, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_nmi(logic [VEC_W-1:0] value);
        settle();
        apb_access(1'b1, APB_DW'(value));
        apb_access(1'b0, '0);           // read-back, checked by u_checker
        nmi_now = value;
    endtask

    // result side: runs of ready broken by stalls, unless told to stay calm
    initial begin
        int n;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            n = output_calm ? 0 : pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin
        int phase_end;
        int n;
        logic [VEC_W-1:0]  v;
        logic [ADDR_W-1:0] a;
        logic [VEC_W-1:0]  nmi_plan [NUM_PHASES];

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        items_sent  = 0;
        nmi_now     = NMI_RESET;
        input_calm  = 1'b0;
        output_calm = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed: empty take, underflow, table extremes, masking ----
        send_op(OP_TAKE, '0, '0);                   // empty queue
        send_op(OP_EXIT, '0, '0);                   // nesting underflow
        send_op(OP_RD_HDL, '0, ADDR_ALL_ONES);      // table zero after reset
        send_op(OP_SET_HDL, '1, ADDR_ALL_ONES);
        send_op(OP_RD_HDL, '1, '0);
        send_op(OP_SET_HDL, '0, '0);
        send_op(OP_RD_HDL, '0, '0);
        send_op(OP_RAISE, '0, '0);
        send_op(OP_RAISE, '1, ADDR_ALL_ONES);
        send_op(OP_TAKE, '0, '0);
        send_op(OP_TAKE, '0, '0);
        send_op(OP_DISABLE, '0, '0);
        send_op(OP_RAISE, 8'd5, '0);                // masked
        send_op(OP_RAISE, NMI_RESET, '0);           // NMI gets through
        send_op(OP_ENABLE, '0, '0);
        send_op(OP_RAISE, 8'd9, '0);
        send_op(OP_CLEAR, '0, '0);
        send_op(OP_TAKE, '0, '0);                   // empty after clear
        send_op(OP_ENTER, '0, '0);
        send_op(OP_EXIT, '0, '0);
        send_op(OP_FIRST_UNUSED, '1, ADDR_ALL_ONES);
        send_op(OP_LAST_CODE, '1, ADDR_ALL_ONES);
        send_op(OP_RAISE, 8'd33, '0);
        send_op(OP_SRESET, '0, '0);                 // clears queue and table
        send_op(OP_RD_HDL, '1, '0);

        // ---- random phases, each with its own NMI vector ----
        nmi_plan[0] = '0;
        nmi_plan[1] = '1;
        nmi_plan[2] = VEC_W'($urandom_range(0, 255));
        nmi_plan[3] = NMI_RESET;
        nmi_plan[4] = VEC_W'($urandom_range(0, 255));
        nmi_plan[5] = VEC_W'($urandom_range(0, 255));

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_nmi(nmi_plan[p]);
            input_calm  = (p == 2);
            output_calm = (p == 2) || (p == 4);
            phase_end   = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                case ($urandom_range(0, 99)) inside
                    [0:31]: begin
                        // raise burst, long enough to reach a full queue
                        n = $urandom_range(1, 20);
                        repeat (n) send_op(OP_RAISE, pick_vector(), $urandom());
                    end
                    [32:56]: begin
                        n = $urandom_range(1, 18);
                        repeat (n) send_op(OP_TAKE, VEC_W'($urandom()), $urandom());
                    end
                    [57:70]: begin
                        // nest then unwind, overshooting both limits at times
                        n = $urandom_range(1, 10);
                        repeat (n) send_op(OP_ENTER, VEC_W'($urandom()), $urandom());
                        n = $urandom_range(1, 10);
                        repeat (n) send_op(OP_EXIT, VEC_W'($urandom()), $urandom());
                    end
                    [71:85]: begin
                        v = pick_vector();
                        a = pick_address();
                        send_op(OP_SET_HDL, v, a);
                        send_op(OP_RD_HDL, v, $urandom());
                        send_op(OP_RD_HDL, pick_vector(), $urandom());
                    end
                    default: begin
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5: send_op(OP_ENABLE, '0, $urandom());
                            6, 7, 8, 9, 10:   send_op(OP_DISABLE, '0, $urandom());
                            11, 12, 13:       send_op(OP_CLEAR, VEC_W'($urandom()), '0);
                            14, 15, 16:
                                send_op(OP_FIRST_UNUSED + OP_W'($urandom_range(0,
                                        OP_LAST_CODE - OP_FIRST_UNUSED)),
                                        VEC_W'($urandom()), $urandom());
                            17: send_op(OP_SRESET, VEC_W'($urandom()), $urandom());
                            default: send_op(OP_RD_HDL, pick_vector(), $urandom());
                        endcase
                    end
                endcase
            end
        end

        // drain, then idle to catch any stray result item
        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: interrupt_queue_controller.f
rtl/core/iqc_pkg.sv
rtl/core/iqc_fifo_mem.sv
rtl/core/iqc_handler_mem.sv
rtl/core/iqc_ctrl.sv
rtl/core/interrupt_queue_controller.sv
verif/iqc_checker.sv
verif/testbench.sv
